// ===== hw/rtl/pcm_pkg.sv =====
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types, constants and codes for the pixel cluster moments block.
// ----------------------------------------------------------------------------
package pcm_pkg;

  localparam int MAX_HITS    = 1024;
  localparam int COORD_BITS  = 8;
  localparam int CHARGE_BITS = 14;

  localparam int HCNT_W  = $clog2(MAX_HITS + 2);
  localparam int SUMQ_W  = 24;
  localparam int SUM1_W  = 32;
  localparam int SUM2_W  = 40;
  localparam int HALF2_W = SUM2_W / 2;

  localparam int MUL_STEPS  = 8;
  localparam int DIV_STEPS  = 80;
  localparam int SQRT_STEPS = 16;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [7:0] GOOD_LIMIT_RESET = 8'd2;

  // Register byte addresses on the configuration port.
  localparam logic [2:0] ADDR_GOOD_WIDTH = 3'd0;

  // Steps of the finishing multiply sequence.
  localparam logic [2:0] MS_WXX_LO = 3'd0;
  localparam logic [2:0] MS_WXX_HI = 3'd1;
  localparam logic [2:0] MS_SX_SQ  = 3'd2;
  localparam logic [2:0] MS_WYY_LO = 3'd3;
  localparam logic [2:0] MS_WYY_HI = 3'd4;
  localparam logic [2:0] MS_SY_SQ  = 3'd5;
  localparam logic [2:0] MS_W_SQ   = 3'd6;
  localparam logic [2:0] MS_DEN    = 3'd7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_SQRT_LOAD,
    OP_SQRT_STEP,
    OP_OUT_LOAD
  } op_t;

  typedef enum logic [1:0] {
    SEL_COL,
    SEL_ROW,
    SEL_SPREAD
  } div_sel_t;

  typedef struct packed {
    logic                    take;
    op_t                     op;
    logic [CNT_W-1:0]        cnt;
    div_sel_t                sel;
  } cmd_t;

  typedef struct packed {
    logic zero_charge;
  } status_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  hit_col;
    logic [COORD_BITS-1:0]  hit_row;
    logic [CHARGE_BITS-1:0] hit_charge;
    logic                   last_hit;
  } hit_t;

  typedef struct packed {
    logic [15:0] centroid_col;
    logic [15:0] centroid_row;
    logic [15:0] spread_rms;
    logic [7:0]  span_col;
    logic [7:0]  span_row;
    logic [7:0]  span_max;
    logic        is_good;
    logic        zero_charge;
    logic        too_many_hits;
  } result_t;

endpackage

// ===== hw/rtl/pcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcm_ctrl
// Sequencer: accepts hits and walks the end-of-cluster arithmetic.
// ----------------------------------------------------------------------------
module pcm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  pcm_pkg::status_t sts,
  output pcm_pkg::cmd_t   cmd
);
  import pcm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK, ST_MUL, ST_DLOAD, ST_DSTEP, ST_DSTORE,
    ST_SLOAD, ST_SSTEP, ST_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  div_sel_t         sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             take, load_out;

  assign take      = in_valid && (state_r == ST_IDLE);
  assign load_out  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.take      = take;
    cmd.op        = OP_NONE;
    cmd.cnt       = cnt_r;
    cmd.sel       = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (take && in_last) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        cnt_nxt = '0;
        sel_nxt = SEL_COL;
        state_nxt = sts.zero_charge ? ST_OUT : ST_MUL;
      end
      ST_MUL: begin
        cmd.op = OP_MUL;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DLOAD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DLOAD: begin
        cmd.op    = OP_DIV_LOAD;
        cnt_nxt   = '0;
        state_nxt = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DSTORE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DSTORE: begin
        cmd.op = OP_DIV_STORE;
        case (sel_r)
          SEL_COL: begin
            sel_nxt   = SEL_ROW;
            state_nxt = ST_DLOAD;
          end
          SEL_ROW: begin
            sel_nxt   = SEL_SPREAD;
            state_nxt = ST_DLOAD;
          end
          default: begin
            state_nxt = ST_SLOAD;
          end
        endcase
      end
      ST_SLOAD: begin
        cmd.op    = OP_SQRT_LOAD;
        cnt_nxt   = '0;
        state_nxt = ST_SSTEP;
      end
      ST_SSTEP: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          cmd.op        = OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sel_r       <= SEL_COL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/pcm_dpath.sv =====
// ----------------------------------------------------------------------------
// pcm_dpath
// Moment accumulators, shared multiplier, restoring divider and square root.
// ----------------------------------------------------------------------------
module pcm_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  pcm_pkg::cmd_t     cmd,
  input  pcm_pkg::hit_t     hit,
  input  logic [7:0]        good_limit,
  output pcm_pkg::status_t  sts,
  output pcm_pkg::result_t  result
);
  import pcm_pkg::*;

  localparam int QC_W = CHARGE_BITS + COORD_BITS;

  // Accumulators.
  logic [SUMQ_W-1:0]     sq_r;
  logic [SUM1_W-1:0]     sx_r, sy_r;
  logic [SUM2_W-1:0]     sxx_r, syy_r;
  logic [COORD_BITS-1:0] min_c_r, max_c_r, min_r_r, max_r_r;
  logic [HCNT_W-1:0]     hcnt_r;

  // Second stage of the per-hit squares.
  logic                  pv_r;
  logic [QC_W-1:0]       qc_r, qr_r;
  logic [COORD_BITS-1:0] pc_r, pr_r;

  // Finishing arithmetic.
  logic [63:0] prod_r, num_r;
  logic [47:0] den_r;
  logic [79:0] dvd_r;
  logic [47:0] rem_r;
  logic [15:0] cen_c_r, cen_r_r, spread_r;
  logic [31:0] x_r;
  logic [16:0] srem_r;

  logic [31:0] mul_a, mul_b;
  logic [47:0] dsor;
  logic [48:0] rr, rdiff;
  logic [18:0] sr, strial, sdiff;
  logic [15:0] quot16;
  logic        accum;
  logic [7:0]  span_c, span_r, span_m;

  result_t res_r;

  assign accum = cmd.take && (hcnt_r < HCNT_W'(MAX_HITS));
  assign sts.zero_charge = (sq_r == '0);

  always_comb begin
    mul_a = 32'(sq_r);
    mul_b = 32'(sxx_r[HALF2_W-1:0]);
    case (cmd.cnt[2:0])
      MS_WXX_LO: mul_b = 32'(sxx_r[HALF2_W-1:0]);
      MS_WXX_HI: mul_b = 32'(sxx_r[SUM2_W-1:HALF2_W]);
      MS_SX_SQ: begin
        mul_a = sx_r;
        mul_b = sx_r;
      end
      MS_WYY_LO: mul_b = 32'(syy_r[HALF2_W-1:0]);
      MS_WYY_HI: mul_b = 32'(syy_r[SUM2_W-1:HALF2_W]);
      MS_SY_SQ: begin
        mul_a = sy_r;
        mul_b = sy_r;
      end
      MS_W_SQ: mul_b = 32'(sq_r);
      default: mul_b = 32'(sq_r);
    endcase
  end

  assign dsor   = (cmd.sel == SEL_SPREAD) ? den_r : 48'(sq_r);
  assign rr     = {rem_r, dvd_r[79]};
  assign rdiff  = rr - {1'b0, dsor};
  assign quot16 = (dvd_r[79:16] != '0) ? 16'hFFFF : dvd_r[15:0];

  assign sr     = {srem_r, x_r[31:30]};
  assign strial = {1'b0, spread_r, 2'b01};
  assign sdiff  = sr - strial;

  assign span_c = 8'(max_c_r - min_c_r);
  assign span_r = 8'(max_r_r - min_r_r);
  assign span_m = (span_c > span_r) ? span_c : span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r    <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxx_r   <= '0;
      syy_r   <= '0;
      min_c_r <= '1;
      max_c_r <= '0;
      min_r_r <= '1;
      max_r_r <= '0;
      hcnt_r  <= '0;
      pv_r    <= 1'b0;
    end else begin
      pv_r <= accum;
      if (pv_r) begin
        sxx_r <= sxx_r + SUM2_W'(qc_r * pc_r);
        syy_r <= syy_r + SUM2_W'(qr_r * pr_r);
      end
      if (cmd.op == OP_OUT_LOAD) begin
        sq_r    <= '0;
        sx_r    <= '0;
        sy_r    <= '0;
        sxx_r   <= '0;
        syy_r   <= '0;
        min_c_r <= '1;
        max_c_r <= '0;
        min_r_r <= '1;
        max_r_r <= '0;
        hcnt_r  <= '0;
      end else if (accum) begin
        sq_r   <= sq_r + SUMQ_W'(hit.hit_charge);
        sx_r   <= sx_r + SUM1_W'(hit.hit_charge * hit.hit_col);
        sy_r   <= sy_r + SUM1_W'(hit.hit_charge * hit.hit_row);
        hcnt_r <= hcnt_r + 1'b1;
        if (hit.hit_col < min_c_r) min_c_r <= hit.hit_col;
        if (hit.hit_col > max_c_r) max_c_r <= hit.hit_col;
        if (hit.hit_row < min_r_r) min_r_r <= hit.hit_row;
        if (hit.hit_row > max_r_r) max_r_r <= hit.hit_row;
      end else if (cmd.take) begin
        hcnt_r <= HCNT_W'(MAX_HITS + 1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accum) begin
      qc_r <= QC_W'(hit.hit_charge * hit.hit_col);
      qr_r <= QC_W'(hit.hit_charge * hit.hit_row);
      pc_r <= hit.hit_col;
      pr_r <= hit.hit_row;
    end
    case (cmd.op)
      OP_MUL: begin
        prod_r <= mul_a * mul_b;
        case (cmd.cnt[2:0])
          MS_WXX_HI: num_r <= prod_r;
          MS_SX_SQ:  num_r <= num_r + (prod_r << HALF2_W);
          MS_WYY_LO: num_r <= num_r - prod_r;
          MS_WYY_HI: num_r <= num_r + prod_r;
          MS_SY_SQ:  num_r <= num_r + (prod_r << HALF2_W);
          MS_W_SQ:   num_r <= num_r - prod_r;
          MS_DEN:    den_r <= prod_r[47:0];
          default:   num_r <= num_r;
        endcase
      end
      OP_DIV_LOAD: begin
        rem_r <= '0;
        if (cmd.sel == SEL_SPREAD) begin
          dvd_r <= {num_r, 16'h0000};
        end else if (cmd.sel == SEL_ROW) begin
          dvd_r <= {40'h0, sy_r, 8'h00};
        end else begin
          dvd_r <= {40'h0, sx_r, 8'h00};
        end
      end
      OP_DIV_STEP: begin
        if (!rdiff[48]) begin
          rem_r <= rdiff[47:0];
        end else begin
          rem_r <= rr[47:0];
        end
        dvd_r <= {dvd_r[78:0], !rdiff[48]};
      end
      OP_DIV_STORE: begin
        if (cmd.sel == SEL_COL) cen_c_r <= quot16;
        if (cmd.sel == SEL_ROW) cen_r_r <= quot16;
      end
      OP_SQRT_LOAD: begin
        x_r      <= (dvd_r[79:32] != '0) ? 32'hFFFF_FFFF : dvd_r[31:0];
        srem_r   <= '0;
        spread_r <= '0;
      end
      OP_SQRT_STEP: begin
        x_r <= {x_r[29:0], 2'b00};
        if (!sdiff[18]) begin
          srem_r   <= sdiff[16:0];
          spread_r <= {spread_r[14:0], 1'b1};
        end else begin
          srem_r   <= sr[16:0];
          spread_r <= {spread_r[14:0], 1'b0};
        end
      end
      OP_OUT_LOAD: begin
        res_r.centroid_col  <= sts.zero_charge ? 16'h0 : cen_c_r;
        res_r.centroid_row  <= sts.zero_charge ? 16'h0 : cen_r_r;
        res_r.spread_rms    <= sts.zero_charge ? 16'h0 : spread_r;
        res_r.span_col      <= span_c;
        res_r.span_row      <= span_r;
        res_r.span_max      <= span_m;
        res_r.is_good       <= (span_m <= good_limit);
        res_r.zero_charge   <= sts.zero_charge;
        res_r.too_many_hits <= (hcnt_r > HCNT_W'(MAX_HITS));
      end
      default: begin
        num_r <= num_r;
      end
    endcase
  end

  assign result = res_r;

endmodule

// ===== hw/rtl/pixel_cluster_moments.sv =====
// ----------------------------------------------------------------------------
// pixel_cluster_moments
// Charge-weighted centroid, RMS spread and spans of one pixel cluster.
// ----------------------------------------------------------------------------
// Hits of a cluster are taken one per cycle while in_stall is low; each word
// carries a column, a row, a charge and a last-hit mark. Charge and the
// charge-weighted first and second moments are accumulated as the hits
// arrive, together with the column and row extremes; hits past MAX_HITS in
// one cluster are dropped and flagged. When the last hit is accepted the
// input stalls while one shared 32x32 multiplier forms the variance numerator
// in 8 steps, one restoring divider produces both centroids and the scaled
// variance at one bit per cycle (three divisions), and a two-bits-per-step
// root produces the spread. The result word then goes to an output register,
// so a waiting result does not block the next cluster's hits. A cluster with
// zero total charge skips the arithmetic and reports zero centroid and spread
// with the zero_charge flag set. The single register, good_limit_r, sets the
// largest span counted as good.
module pixel_cluster_moments (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pcm_pkg::hit_t     in_hit,
  output logic              out_valid,
  input  logic              out_stall,
  output pcm_pkg::result_t  out_result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import pcm_pkg::*;

  cmd_t       cmd;
  status_t    sts;
  logic [7:0] good_limit_r;

  // The configuration port never waits.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_GOOD_WIDTH) ? {24'h0, good_limit_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_limit_r <= GOOD_LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_GOOD_WIDTH) begin
      good_limit_r <= pwdata[7:0];
    end
  end

  pcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_hit.last_hit),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcm_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .hit        (in_hit),
    .good_limit (good_limit_r),
    .sts        (sts),
    .result     (out_result)
  );

endmodule

// ===== hw/rtl/pcm_checker.sv =====
// ----------------------------------------------------------------------------
// pcm_checker
// Port-level checks for the pixel cluster moments block.
// ----------------------------------------------------------------------------
module pcm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input pcm_pkg::hit_t     in_hit,
  input logic              out_valid,
  input logic              out_stall,
  input pcm_pkg::result_t  out_result
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result))
    else $error("result word changed while stalled");

  // The input stalls once a last hit is accepted, while the arithmetic runs.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_hit.last_hit |=> in_stall)
    else $error("input not stalled after last hit");

  a_zero_forced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.zero_charge |->
      out_result.centroid_col == 16'h0 && out_result.centroid_row == 16'h0 &&
      out_result.spread_rms == 16'h0)
    else $error("zero-charge result carries nonzero moments");

  a_span_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.span_max >= out_result.span_col &&
      out_result.span_max >= out_result.span_row &&
      (out_result.span_max == out_result.span_col ||
       out_result.span_max == out_result.span_row))
    else $error("span_max is not the larger span");

endmodule

bind pixel_cluster_moments pcm_checker u_pcm_checker (.*);
